// ===== hw/rtl/asof_pkg.sv =====
// Shared constants and types for the as-of grouped predecessor search.
`timescale 1ns / 1ps

package asof_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DATA_W              = 64;
    localparam int IDX_W               = 10;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_FOUND   = 2'd0;
    localparam logic [1:0] STATUS_NOMATCH = 2'd1;
    localparam logic [1:0] STATUS_STORED  = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] match_index;
        logic             last_result;
    } result_t;

endpackage

// ===== hw/rtl/asof_if.sv =====
// Valid/ready channel interfaces for the request and result words.
`timescale 1ns / 1ps

interface asof_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [63:0] group_key;
    logic signed [63:0] time_value;
    logic               last_query;

    modport source (output valid, output mode, output group_key, output time_value,
                    output last_query, input ready);
    modport sink (input valid, input mode, input group_key, input time_value,
                  input last_query, output ready);
endinterface

interface asof_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] match_index;
    logic       last_result;

    modport source (output valid, output status, output match_index,
                    output last_result, input ready);
    modport sink (input valid, input status, input match_index,
                  input last_result, output ready);
endinterface

// ===== hw/rtl/asof_table.sv =====
// Key and time memories with one write port and one registered read port.
`timescale 1ns / 1ps

module asof_table
    import asof_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [DATA_W-1:0] wr_key,
    input  logic signed [DATA_W-1:0] wr_time,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic signed [DATA_W-1:0] rd_key,
    output logic signed [DATA_W-1:0] rd_time
);

    logic signed [DATA_W-1:0] key_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] time_mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            time_mem[wr_addr] <= wr_time;
        end
        rd_key  <= key_mem[rd_addr];
        rd_time <= time_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/asof_ctrl.sv =====
// Sequencer that clears and appends entries and runs the three binary searches over the table.
`timescale 1ns / 1ps

module asof_ctrl
    import asof_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               in_mode,
    input  logic signed [DATA_W-1:0] in_key,
    input  logic signed [DATA_W-1:0] in_time,
    input  logic                     in_last,
    output logic                     wr_en,
    output logic [ADDR_W-1:0]        wr_addr,
    output logic signed [DATA_W-1:0] wr_key,
    output logic signed [DATA_W-1:0] wr_time,
    output logic [ADDR_W-1:0]        rd_addr,
    input  logic signed [DATA_W-1:0] rd_key,
    input  logic signed [DATA_W-1:0] rd_time,
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOWER,
        ST_CHECK,
        ST_UPPER,
        ST_PRED,
        ST_RESULT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [CNT_W-1:0]         start_reg, start_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] time_reg, time_next;
    result_t                  res_reg, res_next;

    logic                     go;
    logic [CNT_W-1:0]         step_lo;
    logic [CNT_W-1:0]         step_hi;
    logic [CNT_W-1:0]         step_mid;
    logic                     more;
    logic [CNT_W-1:0]         found_idx;
    logic [IDX_W+CNT_W-1:0]   found_wide;

    always_comb
    begin
        case (state_reg)
            ST_LOWER: go = rd_key < key_reg;
            ST_UPPER: go = rd_key <= key_reg;
            default:  go = rd_time <= time_reg;
        endcase
        step_lo    = go ? mid_reg + CNT_W'(1) : lo_reg;
        step_hi    = go ? hi_reg : mid_reg;
        step_mid   = step_lo + ((step_hi - step_lo) >> 1);
        more       = step_lo < step_hi;
        found_idx  = step_lo - CNT_W'(1);
        found_wide = {{IDX_W{1'b0}}, found_idx};
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        start_next = start_reg;
        key_next   = key_reg;
        time_next  = time_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        wr_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next   = in_key;
                    time_next  = in_time;
                    state_next = ST_RESULT;
                    res_next   = '{status: STATUS_NOMATCH, match_index: '0, last_result: 1'b0};
                    case (in_mode)
                        MODE_CLEAR:
                        begin
                            count_next      = '0;
                            res_next.status = STATUS_STORED;
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                res_next.status = STATUS_STORED;
                            end
                        end
                        MODE_QUERY:
                        begin
                            res_next.last_result = in_last;
                            if (count_reg != '0)
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = count_reg >> 1;
                                state_next = ST_LOWER;
                            end
                        end
                        default:
                        begin
                            res_next.status = STATUS_NOMATCH;
                        end
                    endcase
                end
            end
            ST_LOWER:
            begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (more)
                begin
                    mid_next = step_mid;
                end
                else if (step_lo >= count_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    mid_next   = step_lo;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (rd_key != key_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    start_next = lo_reg;
                    hi_next    = count_reg;
                    mid_next   = lo_reg + ((count_reg - lo_reg) >> 1);
                    state_next = ST_UPPER;
                end
            end
            ST_UPPER:
            begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (more)
                begin
                    mid_next = step_mid;
                end
                else if (step_lo > start_reg)
                begin
                    lo_next    = start_reg;
                    hi_next    = step_lo;
                    mid_next   = start_reg + ((step_lo - start_reg) >> 1);
                    state_next = ST_PRED;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_PRED:
            begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (more)
                begin
                    mid_next = step_mid;
                end
                else
                begin
                    if (step_lo > start_reg)
                    begin
                        res_next.status      = STATUS_FOUND;
                        res_next.match_index = found_wide[IDX_W-1:0];
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mid_reg   <= '0;
            start_reg <= '0;
            key_reg   <= '0;
            time_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            start_reg <= start_next;
            key_reg   <= key_next;
            time_reg  <= time_next;
            res_reg   <= res_next;
        end
    end

    assign wr_addr   = count_reg[ADDR_W-1:0];
    assign wr_key    = in_key;
    assign wr_time   = in_time;
    assign rd_addr   = mid_next[ADDR_W-1:0];
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

endmodule

// ===== hw/rtl/asof_out_reg.sv =====
// Output register that holds one result word until the sink takes it.
`timescale 1ns / 1ps

module asof_out_reg
    import asof_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    output logic       res_ready,
    input  result_t    res,
    asof_out_if.source out_ch
);

    logic    valid_reg;
    result_t word_reg;

    assign res_ready = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            word_reg <= res;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.status      = word_reg.status;
    assign out_ch.match_index = word_reg.match_index;
    assign out_ch.last_result = word_reg.last_result;

endmodule

// ===== hw/rtl/asof_group_predecessor_search.sv =====
// Top level of the as-of grouped predecessor search.
`timescale 1ns / 1ps

// The block keeps a table of up to TABLE_DEPTH (group key, time) entries in two
// single-port-read memories and answers one request word at a time. A query runs
// three binary searches over the table: a lower bound on the key, one read to
// confirm the key, an upper bound on the key starting at the group start, and a
// predecessor search over the group's times. Each search step is one memory read,
// and a query takes fewer steps for a missing key or a small group. The next
// request word is taken once the current result sits in the output register.
// Entries should be appended in ascending key and time order for the answers to
// mean an as-of match.

module asof_group_predecessor_search
    import asof_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    asof_in_if.sink   in_ch,
    asof_out_if.source out_ch
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_key;
    logic signed [DATA_W-1:0] wr_time;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] rd_key;
    logic signed [DATA_W-1:0] rd_time;
    logic                     res_valid;
    logic                     res_ready;
    result_t                  res;
    logic                     in_ready;

    assign in_ch.ready = in_ready;

    asof_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_time (wr_time),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_time (rd_time)
    );

    asof_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .in_mode   (in_ch.mode),
        .in_key    (in_ch.group_key),
        .in_time   (in_ch.time_value),
        .in_last   (in_ch.last_query),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_time   (wr_time),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_time   (rd_time),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    asof_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_ch    (out_ch)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the as-of grouped predecessor search block.
`timescale 1ns / 1ps

module tb_top;
    import asof_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint KEY_MIN = 64'sh8000_0000_0000_0000;
    localparam longint KEY_MAX = 64'sh7fff_ffff_ffff_ffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    asof_in_if  in_ch();
    asof_out_if out_ch();

    asof_group_predecessor_search #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    longint  key_table [TABLE_DEPTH];
    longint  time_table [TABLE_DEPTH];
    int      entry_total = 0;
    result_t pending_results [$];
    int      fail_count = 0;
    int      words_sent = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_request = 0;
    int      hold_left = 0;

    function automatic result_t predict_search_result(logic [1:0] mode, longint key,
                                                      longint tv, logic last);
        result_t r;
        int lo;
        int hi;
        int mid;
        int start;
        r.status      = STATUS_NOMATCH;
        r.match_index = '0;
        r.last_result = 1'b0;
        case (mode)
            MODE_CLEAR:
            begin
                entry_total = 0;
                r.status = STATUS_STORED;
            end
            MODE_APPEND:
            begin
                if (entry_total >= TABLE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    key_table[entry_total]  = key;
                    time_table[entry_total] = tv;
                    entry_total++;
                    r.status = STATUS_STORED;
                end
            end
            MODE_QUERY:
            begin
                r.last_result = last;
                lo = 0;
                hi = entry_total;
                while (lo < hi)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    if (key_table[mid] < key) lo = mid + 1;
                    else hi = mid;
                end
                if (lo < entry_total && key_table[lo] == key)
                begin
                    start = lo;
                    hi = entry_total;
                    while (lo < hi)
                    begin
                        mid = lo + ((hi - lo) >> 1);
                        if (key_table[mid] <= key) lo = mid + 1;
                        else hi = mid;
                    end
                    hi = lo;
                    lo = start;
                    while (lo < hi)
                    begin
                        mid = lo + ((hi - lo) >> 1);
                        if (time_table[mid] <= tv) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo > start)
                    begin
                        r.status = STATUS_FOUND;
                        r.match_index = IDX_W'(lo - 1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic longint pick_value();
        case ($urandom_range(0, 5))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return -64'sd1;
            3:       return longint'($urandom_range(0, 40)) - 20;
            default: return longint'({$urandom, $urandom});
        endcase
    endfunction

    task automatic note_failure(input string what, input result_t want, input result_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("mismatch (%s): expected status %0d index %0d last %0b,", what,
                     want.status, want.match_index, want.last_result);
            $display("    got status %0d index %0d last %0b",
                     got.status, got.match_index, got.last_result);
        end
    endtask

    task automatic send_word(input logic [1:0] mode, input longint key, input longint tv,
                             input logic last);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.group_key  <= key;
        in_ch.time_value <= tv;
        in_ch.last_query <= last;
        do @(posedge clk); while (!in_ch.ready);
        pending_results.push_back(predict_search_result(mode, key, tv, last));
        if (mode != MODE_UNUSED) words_sent++;
    endtask

    task automatic wait_for_results();
        int waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_results.size() != 0 && waited < 50000);
    endtask

    task automatic test_directed();
        send_idle_pct = 27;
        recv_idle_pct = 46;
        send_word(MODE_CLEAR, 0, 0, 1'b0);
        send_word(MODE_QUERY, 0, 0, 1'b1);
        send_word(MODE_APPEND, KEY_MIN, KEY_MIN, 1'b1);
        send_word(MODE_APPEND, KEY_MIN, KEY_MAX, 1'b0);
        send_word(MODE_APPEND, -64'sd1, 0, 1'b0);
        send_word(MODE_APPEND, 0, -64'sd5, 1'b0);
        send_word(MODE_APPEND, 0, 64'sd5, 1'b0);
        send_word(MODE_APPEND, 0, 64'sd5, 1'b0);
        send_word(MODE_APPEND, KEY_MAX, KEY_MIN, 1'b0);
        send_word(MODE_APPEND, KEY_MAX, KEY_MAX, 1'b0);
        send_word(MODE_QUERY, KEY_MIN, KEY_MIN, 1'b0);
        send_word(MODE_QUERY, 0, 64'sd4, 1'b0);
        send_word(MODE_QUERY, 0, 64'sd5, 1'b1);
        send_word(MODE_QUERY, 0, -64'sd6, 1'b0);
        send_word(MODE_QUERY, -64'sd1, KEY_MAX, 1'b0);
        send_word(MODE_QUERY, 64'sd1, 0, 1'b0);
        send_word(MODE_QUERY, KEY_MAX, KEY_MAX, 1'b1);
        send_word(MODE_UNUSED, KEY_MAX, KEY_MAX, 1'b1);
        send_word(MODE_APPEND, -64'sd7, 0, 1'b0);
        send_word(MODE_QUERY, -64'sd7, 0, 1'b0);
        send_word(MODE_QUERY, KEY_MAX, 64'sd3, 1'b0);
        send_word(MODE_CLEAR, KEY_MAX, KEY_MAX, 1'b1);
        send_word(MODE_QUERY, KEY_MIN, KEY_MAX, 1'b1);
        wait_for_results();
    endtask

    task automatic test_full_table();
        send_idle_pct = 27;
        recv_idle_pct = 46;
        send_word(MODE_CLEAR, 0, 0, 1'b0);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            send_word(MODE_APPEND, longint'(i / 16) - 32, longint'(i % 16) * 1000 - 5000,
                      1'b0);
        end
        send_word(MODE_APPEND, KEY_MAX, KEY_MAX, 1'b0);
        send_word(MODE_QUERY, longint'((TABLE_DEPTH - 1) / 16) - 32, KEY_MAX, 1'b1);
        send_word(MODE_QUERY, -64'sd32, KEY_MIN, 1'b0);
        send_word(MODE_QUERY, -64'sd1, 64'sd2500, 1'b0);
        send_word(MODE_QUERY, 0, -64'sd5000, 1'b1);
        send_word(MODE_CLEAR, 0, 0, 1'b0);
        send_word(MODE_APPEND, KEY_MAX, KEY_MAX, 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int item_goal);
        longint keys [$];
        longint times [$];
        longint probe_keys [$];
        longint probe_times [$];
        longint key;
        longint tv;
        int goal;
        int queries;
        int pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = words_sent + item_goal;
        while (words_sent < goal)
        begin
            if ($urandom_range(99) < 75)
            begin
                if ($urandom_range(3) != 0) send_word(MODE_CLEAR, pick_value(), pick_value(),
                                                      1'($urandom));
                keys.delete();
                probe_keys.delete();
                probe_times.delete();
                repeat ($urandom_range(1, 4)) keys.push_back(pick_value());
                keys.sort();
                foreach (keys[g])
                begin
                    times.delete();
                    repeat ($urandom_range(1, 6)) times.push_back(pick_value());
                    times.sort();
                    foreach (times[t])
                    begin
                        send_word(MODE_APPEND, keys[g], times[t], 1'($urandom));
                        probe_keys.push_back(keys[g]);
                        probe_times.push_back(times[t]);
                    end
                end
                queries = $urandom_range(2, 8);
                for (int q = 0; q < queries; q++)
                begin
                    pick = $urandom_range(0, probe_keys.size() - 1);
                    key = probe_keys[pick];
                    tv = probe_times[pick] + longint'($urandom_range(0, 2)) - 1;
                    case ($urandom_range(0, 9))
                        0:       key = key + 1;
                        1:       key = key - 1;
                        2:       key = pick_value();
                        3:       tv = pick_value();
                        default: ;
                    endcase
                    send_word(MODE_QUERY, key, tv, q == queries - 1);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_word(2'($urandom_range(0, 3)), pick_value(), pick_value(),
                              1'($urandom));
                end
            end
        end
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 400;
        send_word(MODE_CLEAR, 0, 0, 1'b0);
        for (int i = 0; i < 10; i++) send_word(MODE_APPEND, 64'sd3, longint'(i) * 10, 1'b0);
        for (int i = 0; i < 20; i++)
        begin
            send_word(MODE_QUERY, 64'sd3, longint'($urandom_range(0, 110)) - 5, 1'($urandom));
        end
        wait_for_results();
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request > 0)
            begin
                hold_left = hold_request - 1;
                hold_request = 0;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.status      = out_ch.status;
            got.match_index = out_ch.match_index;
            got.last_result = out_ch.last_result;
            if (pending_results.size() == 0)
            begin
                want = '0;
                note_failure("unexpected word", want, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.match_index !== want.match_index ||
                    got.last_result !== want.last_result)
                begin
                    note_failure("field", want, got);
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_CLEAR;
        in_ch.group_key  <= '0;
        in_ch.time_value <= '0;
        in_ch.last_query <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random_traffic(27, 46, 40);
        test_random_traffic(46, 27, 40);
        test_random_traffic(0, 0, 40);
        test_output_backpressure();

        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
